// ===== rtl/core/lidar_sector_merge_sequencer_defines.svh =====
// Assertion macros for the lidar sector merge sequencer.
// Included by the RTL files that carry concurrent assertions; no other dependencies.
`ifndef LIDAR_SECTOR_MERGE_SEQUENCER_DEFINES_SVH
`define LIDAR_SECTOR_MERGE_SEQUENCER_DEFINES_SVH

`ifndef NO_ASSERTIONS

// Check that a property holds at every clock edge outside reset
`define LSMS_ASSERT(lbl, clk, rstn, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
		else $error("lsms assertion failed");

// Check that a condition never holds outside reset
`define LSMS_ASSERT_NEVER(lbl, clk, rstn, cond) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
		else $error("lsms forbidden condition seen");

`else

`define LSMS_ASSERT(lbl, clk, rstn, prop)
`define LSMS_ASSERT_NEVER(lbl, clk, rstn, cond)

`endif

`endif

// ===== rtl/core/lsms_pkg.sv =====
// Package for the lidar sector merge sequencer: field widths, register indexes,
// reset values and fixed window bounds. No dependencies.
package lsms_pkg;

	// Field widths
	localparam int ANGLE_W = 12;
	localparam int RANGE_W = 14;
	localparam int STEER_W = 8;
	localparam int SPEED_W = 16;
	localparam int TICK_W  = 8;
	localparam int COUNT_W = TICK_W + 1;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_MERGE_SPEED     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_STEER_LEFT      = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_STEER_STRAIGHT  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_WAIT_TICKS      = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_REAR_ANGLE_MIN  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_REAR_ANGLE_MAX  = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_REAR_RANGE_MIN  = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_FRONT_RANGE_MIN = 3'd7;

	// Register reset values
	localparam logic [SPEED_W-1:0]        RST_MERGE_SPEED     = 16'd650;
	localparam logic [STEER_W-1:0]        RST_STEER_LEFT      = 8'd61;
	localparam logic [STEER_W-1:0]        RST_STEER_STRAIGHT  = 8'd85;
	localparam logic [TICK_W-1:0]         RST_WAIT_TICKS      = 8'd8;
	localparam logic signed [ANGLE_W-1:0] RST_REAR_ANGLE_MIN  = 12'sd800;
	localparam logic signed [ANGLE_W-1:0] RST_REAR_ANGLE_MAX  = 12'sd1800;
	localparam logic [RANGE_W-1:0]        RST_REAR_RANGE_MIN  = 14'd400;
	localparam logic [RANGE_W-1:0]        RST_FRONT_RANGE_MIN = 14'd200;

	// Sequencer steering command right after reset
	localparam logic [STEER_W-1:0] RST_STEER_CMD = 8'd85;

	// Fixed window and completion bounds (tenths of a degree, millimetres)
	localparam logic signed [ANGLE_W-1:0] FRONT_ANGLE_MIN = -12'sd150;
	localparam logic signed [ANGLE_W-1:0] FRONT_ANGLE_MAX = 12'sd300;
	localparam logic [RANGE_W-1:0]        RANGE_MAX_MM    = 14'd800;
	localparam logic [RANGE_W-1:0]        DONE_RANGE_HI   = 14'd300;
	localparam logic [RANGE_W-1:0]        DONE_RANGE_LO   = 14'd100;

endpackage

// ===== rtl/core/lidar_sector_merge_sequencer.sv =====
// Top level of the lidar sector merge sequencer: point window filter and merge sequencer.
// Depends on lsms_pkg and lidar_sector_merge_sequencer_defines.svh.

// One lidar point is taken per clock unless a scan-ending point is held in the input
// register. An accepted point lands in an input register; from there the window
// compares, the kept range and the sequencer step are done and, on the last point of a
// scan, a result goes into the output register. Points that do not end a scan never
// wait on the output side; a scan-ending point waits in the input register only
// while the previous result is still held by the consumer. Configuration is taken
// through cfg_we / cfg_index / cfg_data and must only be written while no point is in
// flight and no result is pending.
`include "lidar_sector_merge_sequencer_defines.svh"

module lidar_sector_merge_sequencer (
	input  logic                                     clk,
	input  logic                                     arst_n,
	// Configuration write port
	input  logic                                     cfg_we,
	input  logic [lsms_pkg::CFG_IDX_W-1:0]           cfg_index,
	input  logic [lsms_pkg::CFG_DATA_W-1:0]          cfg_data,
	// Point input channel
	input  logic                                     in_valid,
	output logic                                     in_ready,
	input  logic signed [lsms_pkg::ANGLE_W-1:0]      point_angle,
	input  logic [lsms_pkg::RANGE_W-1:0]             point_range,
	input  logic                                     point_valid,
	input  logic                                     scan_last,
	// Result channel
	output logic                                     out_valid,
	input  logic                                     out_ready,
	output logic [lsms_pkg::STEER_W-1:0]             steer_cmd,
	output logic [lsms_pkg::SPEED_W-1:0]             speed_cmd,
	output logic                                     merge_done,
	output logic [lsms_pkg::RANGE_W-1:0]             scan_range
);

	// Configuration registers
	logic [lsms_pkg::SPEED_W-1:0]        merge_speed_q;
	logic [lsms_pkg::STEER_W-1:0]        steer_left_q;
	logic [lsms_pkg::STEER_W-1:0]        steer_straight_q;
	logic [lsms_pkg::TICK_W-1:0]         wait_ticks_q;
	logic signed [lsms_pkg::ANGLE_W-1:0] rear_angle_min_q;
	logic signed [lsms_pkg::ANGLE_W-1:0] rear_angle_max_q;
	logic [lsms_pkg::RANGE_W-1:0]        rear_range_min_q;
	logic [lsms_pkg::RANGE_W-1:0]        front_range_min_q;

	// Input stage
	logic                                valid_s1;
	logic signed [lsms_pkg::ANGLE_W-1:0] angle_s1;
	logic [lsms_pkg::RANGE_W-1:0]        range_s1;
	logic                                point_valid_s1;
	logic                                last_s1;

	// Sequencer state
	logic [lsms_pkg::RANGE_W-1:0]        window_range_q;
	logic                                waiting_q;
	logic                                merge_drive_q;
	logic                                left_seen_q;
	logic                                finished_q;
	logic                                front_on_q;
	logic [lsms_pkg::COUNT_W-1:0]        tick_q;
	logic [lsms_pkg::STEER_W-1:0]        steer_q;
	logic [lsms_pkg::SPEED_W-1:0]        speed_q;
	logic                                done_q;

	// Output register
	logic                                out_valid_q;
	logic [lsms_pkg::STEER_W-1:0]        steer_out_q;
	logic [lsms_pkg::SPEED_W-1:0]        speed_out_q;
	logic                                done_out_q;
	logic [lsms_pkg::RANGE_W-1:0]        range_out_q;

	// Datapath signals
	logic                                out_free;
	logic                                s1_fire;
	logic                                in_fire;
	logic                                hit_front;
	logic                                hit_rear;
	logic                                hit;
	logic [lsms_pkg::RANGE_W-1:0]        d;
	logic                                within_wait;
	logic                                waiting_d;
	logic                                merge_drive_d;
	logic                                left_seen_d;
	logic                                finished_d;
	logic                                front_on_d;
	logic [lsms_pkg::COUNT_W-1:0]        tick_d;
	logic [lsms_pkg::STEER_W-1:0]        steer_d;
	logic [lsms_pkg::SPEED_W-1:0]        speed_d;
	logic                                done_d;

	// Handshake: a non-final point never needs the output slot
	assign out_free = !out_valid_q || out_ready;
	assign s1_fire  = valid_s1 && (!last_s1 || out_free);
	assign in_ready = !valid_s1 || s1_fire;
	assign in_fire  = in_valid && in_ready;

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			merge_speed_q     <= lsms_pkg::RST_MERGE_SPEED;
			steer_left_q      <= lsms_pkg::RST_STEER_LEFT;
			steer_straight_q  <= lsms_pkg::RST_STEER_STRAIGHT;
			wait_ticks_q      <= lsms_pkg::RST_WAIT_TICKS;
			rear_angle_min_q  <= lsms_pkg::RST_REAR_ANGLE_MIN;
			rear_angle_max_q  <= lsms_pkg::RST_REAR_ANGLE_MAX;
			rear_range_min_q  <= lsms_pkg::RST_REAR_RANGE_MIN;
			front_range_min_q <= lsms_pkg::RST_FRONT_RANGE_MIN;
		end else if (cfg_we) begin
			unique case (cfg_index)
				lsms_pkg::REG_MERGE_SPEED: begin
					merge_speed_q <= cfg_data[lsms_pkg::SPEED_W-1:0];
				end
				lsms_pkg::REG_STEER_LEFT: begin
					steer_left_q <= cfg_data[lsms_pkg::STEER_W-1:0];
				end
				lsms_pkg::REG_STEER_STRAIGHT: begin
					steer_straight_q <= cfg_data[lsms_pkg::STEER_W-1:0];
				end
				lsms_pkg::REG_WAIT_TICKS: begin
					wait_ticks_q <= cfg_data[lsms_pkg::TICK_W-1:0];
				end
				lsms_pkg::REG_REAR_ANGLE_MIN: begin
					rear_angle_min_q <= $signed(cfg_data[lsms_pkg::ANGLE_W-1:0]);
				end
				lsms_pkg::REG_REAR_ANGLE_MAX: begin
					rear_angle_max_q <= $signed(cfg_data[lsms_pkg::ANGLE_W-1:0]);
				end
				lsms_pkg::REG_REAR_RANGE_MIN: begin
					rear_range_min_q <= cfg_data[lsms_pkg::RANGE_W-1:0];
				end
				lsms_pkg::REG_FRONT_RANGE_MIN: begin
					front_range_min_q <= cfg_data[lsms_pkg::RANGE_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	// Input register: hold the point until it is processed
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			angle_s1       <= point_angle;
			range_s1       <= point_range;
			point_valid_s1 <= point_valid;
			last_s1        <= scan_last;
		end
	end

	// Window test on the active window, all bounds inclusive
	assign hit_front = (angle_s1 >= lsms_pkg::FRONT_ANGLE_MIN)
		&& (angle_s1 <= lsms_pkg::FRONT_ANGLE_MAX)
		&& (range_s1 <= lsms_pkg::RANGE_MAX_MM)
		&& (range_s1 >= front_range_min_q);
	assign hit_rear = (angle_s1 >= rear_angle_min_q)
		&& (angle_s1 <= rear_angle_max_q)
		&& (range_s1 <= lsms_pkg::RANGE_MAX_MM)
		&& (range_s1 >= rear_range_min_q);
	assign hit = front_on_q ? hit_front : hit_rear;
	assign d   = (point_valid_s1 && hit) ? range_s1 : window_range_q;

	assign within_wait = tick_q <= {1'b0, wait_ticks_q};

	// Sequencer step taken at the end of a scan
	always_comb begin
		waiting_d     = waiting_q;
		merge_drive_d = merge_drive_q;
		left_seen_d   = left_seen_q;
		finished_d    = finished_q;
		front_on_d    = front_on_q;
		tick_d        = tick_q;
		steer_d       = steer_q;
		speed_d       = speed_q;
		done_d        = done_q;

		priority if ((d != '0) && !waiting_q && !merge_drive_q && !finished_q) begin
			waiting_d = 1'b1;
		end else if (waiting_q) begin
			// Pull out to the left while the count runs, then start the merge drive
			priority if (within_wait && (d == '0)) begin
				steer_d     = steer_left_q;
				speed_d     = merge_speed_q;
				left_seen_d = 1'b1;
				tick_d      = tick_q + 1'b1;
			end else if (within_wait && left_seen_q) begin
				steer_d = steer_left_q;
				speed_d = merge_speed_q;
				tick_d  = tick_q + 1'b1;
			end else if (!within_wait) begin
				merge_drive_d = 1'b1;
				waiting_d     = 1'b0;
			end else begin
				// Blocked pull-out: hold everything
			end
		end else if (merge_drive_q && !finished_q) begin
			front_on_d = 1'b1;
			steer_d    = steer_straight_q;
			speed_d    = merge_speed_q;
		end else begin
		end

		// Flag completion once the gap ahead closes into the target band
		if (merge_drive_d && !waiting_d && (d < lsms_pkg::DONE_RANGE_HI)
				&& (d > lsms_pkg::DONE_RANGE_LO)) begin
			done_d     = 1'b1;
			finished_d = 1'b1;
		end
	end

	// State update: kept range every point, sequencer only at scan end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_range_q <= '0;
			waiting_q      <= 1'b0;
			merge_drive_q  <= 1'b0;
			left_seen_q    <= 1'b0;
			finished_q     <= 1'b0;
			front_on_q     <= 1'b0;
			tick_q         <= '0;
			steer_q        <= lsms_pkg::RST_STEER_CMD;
			speed_q        <= '0;
			done_q         <= 1'b0;
		end else if (s1_fire) begin
			if (last_s1) begin
				window_range_q <= '0;
				waiting_q      <= waiting_d;
				merge_drive_q  <= merge_drive_d;
				left_seen_q    <= left_seen_d;
				finished_q     <= finished_d;
				front_on_q     <= front_on_d;
				tick_q         <= tick_d;
				steer_q        <= steer_d;
				speed_q        <= speed_d;
				done_q         <= done_d;
			end else begin
				window_range_q <= d;
			end
		end
	end

	// Output register: load on a scan-ending transaction, drop when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_fire && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_fire && last_s1) begin
			steer_out_q <= steer_d;
			speed_out_q <= speed_d;
			done_out_q  <= done_d;
			range_out_q <= d;
		end
	end

	assign out_valid  = out_valid_q;
	assign steer_cmd  = steer_out_q;
	assign speed_cmd  = speed_out_q;
	assign merge_done = done_out_q;
	assign scan_range = range_out_q;

	// Sequencer consistency checks
	`LSMS_ASSERT_NEVER(a_wait_and_drive, clk, arst_n, waiting_q && merge_drive_q)
	`LSMS_ASSERT_NEVER(a_finish_needs_drive, clk, arst_n, finished_q && !merge_drive_q)
	`LSMS_ASSERT_NEVER(a_front_needs_drive, clk, arst_n, front_on_q && !merge_drive_q)
	`LSMS_ASSERT(a_done_tracks_finish, clk, arst_n, done_q == finished_q)

endmodule

// ===== test/lsms_scan_checker.sv =====
`timescale 1ns / 1ps
// Scoreboard for the lidar sector merge sequencer: mirrors register writes, predicts
// the result of each scan-ending point and compares every accepted result with it.
// Depends on lsms_pkg.
module lsms_scan_checker (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [lsms_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [lsms_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  logic                                in_valid,
	input  logic                                in_ready,
	input  logic signed [lsms_pkg::ANGLE_W-1:0] point_angle,
	input  logic [lsms_pkg::RANGE_W-1:0]        point_range,
	input  logic                                point_valid,
	input  logic                                scan_last,
	input  logic                                out_valid,
	input  logic                                out_ready,
	input  logic [lsms_pkg::STEER_W-1:0]        steer_cmd,
	input  logic [lsms_pkg::SPEED_W-1:0]        speed_cmd,
	input  logic                                merge_done,
	input  logic [lsms_pkg::RANGE_W-1:0]        scan_range,
	output int                                  fail_count,
	output int                                  pending,
	output int                                  results_checked,
	output logic                                done_reached
);
	import lsms_pkg::*;

	typedef struct packed {
		logic [STEER_W-1:0] steer;
		logic [SPEED_W-1:0] speed;
		logic               done;
		logic [RANGE_W-1:0] scan_mm;
	} scan_result_t;

	// Mirrored register file
	logic [SPEED_W-1:0]        cfg_speed;
	logic [STEER_W-1:0]        cfg_steer_left;
	logic [STEER_W-1:0]        cfg_steer_straight;
	logic [TICK_W-1:0]         cfg_wait;
	logic signed [ANGLE_W-1:0] cfg_rear_amin;
	logic signed [ANGLE_W-1:0] cfg_rear_amax;
	logic [RANGE_W-1:0]        cfg_rear_rmin;
	logic [RANGE_W-1:0]        cfg_front_rmin;

	// Predicted filter and sequencer state
	logic [RANGE_W-1:0] kept_range;
	logic               in_waiting;
	logic               in_merge;
	logic               pulled_left;
	logic               merge_complete;
	logic               front_active;
	logic [COUNT_W-1:0] scan_ticks;
	logic [STEER_W-1:0] steer_now;
	logic [SPEED_W-1:0] speed_now;
	logic               done_now;

	scan_result_t expected_scans[$];
	int mismatches;
	int checked;

	task automatic check_field(input string name, input int unsigned exp_v,
			input int unsigned act_v);
		if (exp_v != act_v) begin
			$error("%s mismatch: expected %0d, actual %0d", name, exp_v, act_v);
			mismatches++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		logic hit;
		logic [RANGE_W-1:0] seen;
		scan_result_t want;
		if (!arst_n) begin
			cfg_speed          = RST_MERGE_SPEED;
			cfg_steer_left     = RST_STEER_LEFT;
			cfg_steer_straight = RST_STEER_STRAIGHT;
			cfg_wait           = RST_WAIT_TICKS;
			cfg_rear_amin      = RST_REAR_ANGLE_MIN;
			cfg_rear_amax      = RST_REAR_ANGLE_MAX;
			cfg_rear_rmin      = RST_REAR_RANGE_MIN;
			cfg_front_rmin     = RST_FRONT_RANGE_MIN;
			kept_range     = '0;
			in_waiting     = 1'b0;
			in_merge       = 1'b0;
			pulled_left    = 1'b0;
			merge_complete = 1'b0;
			front_active   = 1'b0;
			scan_ticks     = '0;
			steer_now      = RST_STEER_CMD;
			speed_now      = '0;
			done_now       = 1'b0;
			expected_scans.delete();
			mismatches = 0;
			checked    = 0;
			fail_count      <= 0;
			pending         <= 0;
			results_checked <= 0;
			done_reached    <= 1'b0;
		end else begin
			// Compare an accepted result transaction with the oldest prediction
			if (out_valid && out_ready) begin
				if (expected_scans.size() == 0) begin
					$error("unexpected result: steer %0d speed %0d done %0d range %0d",
						steer_cmd, speed_cmd, merge_done, scan_range);
					mismatches++;
				end else begin
					want = expected_scans.pop_front();
					check_field("steer_cmd", want.steer, steer_cmd);
					check_field("speed_cmd", want.speed, speed_cmd);
					check_field("merge_done", want.done, merge_done);
					check_field("scan_range", want.scan_mm, scan_range);
					checked++;
				end
				if (merge_done)
					done_reached <= 1'b1;
			end

			// Mirror register writes
			if (cfg_we) begin
				case (cfg_index)
					REG_MERGE_SPEED:     cfg_speed = cfg_data[SPEED_W-1:0];
					REG_STEER_LEFT:      cfg_steer_left = cfg_data[STEER_W-1:0];
					REG_STEER_STRAIGHT:  cfg_steer_straight = cfg_data[STEER_W-1:0];
					REG_WAIT_TICKS:      cfg_wait = cfg_data[TICK_W-1:0];
					REG_REAR_ANGLE_MIN:  cfg_rear_amin = cfg_data[ANGLE_W-1:0];
					REG_REAR_ANGLE_MAX:  cfg_rear_amax = cfg_data[ANGLE_W-1:0];
					REG_REAR_RANGE_MIN:  cfg_rear_rmin = cfg_data[RANGE_W-1:0];
					REG_FRONT_RANGE_MIN: cfg_front_rmin = cfg_data[RANGE_W-1:0];
					default: ;
				endcase
			end

			// Window filter: keep the range of the last in-window point
			if (in_valid && in_ready) begin
				if (front_active)
					hit = point_angle >= FRONT_ANGLE_MIN && point_angle <= FRONT_ANGLE_MAX &&
						point_range <= RANGE_MAX_MM && point_range >= cfg_front_rmin;
				else
					hit = point_angle >= cfg_rear_amin && point_angle <= cfg_rear_amax &&
						point_range <= RANGE_MAX_MM && point_range >= cfg_rear_rmin;
				if (point_valid && hit)
					kept_range = point_range;

				// Step the merge sequencer once per scan
				if (scan_last) begin
					seen = kept_range;
					if (seen != 0 && !in_waiting && !in_merge && !merge_complete) begin
						in_waiting = 1'b1;
					end else if (in_waiting) begin
						if (scan_ticks <= cfg_wait && seen == 0) begin
							steer_now   = cfg_steer_left;
							speed_now   = cfg_speed;
							pulled_left = 1'b1;
							scan_ticks  = scan_ticks + 1'b1;
						end else if (scan_ticks <= cfg_wait && pulled_left) begin
							steer_now  = cfg_steer_left;
							speed_now  = cfg_speed;
							scan_ticks = scan_ticks + 1'b1;
						end else if (scan_ticks > cfg_wait) begin
							in_merge   = 1'b1;
							in_waiting = 1'b0;
						end
					end else if (in_merge && !merge_complete) begin
						front_active = 1'b1;
						steer_now    = cfg_steer_straight;
						speed_now    = cfg_speed;
					end

					// Flag completion once the gap ahead is in the done band
					if (in_merge && !in_waiting && seen < DONE_RANGE_HI &&
							seen > DONE_RANGE_LO) begin
						done_now       = 1'b1;
						merge_complete = 1'b1;
					end

					want.steer   = steer_now;
					want.speed   = speed_now;
					want.done    = done_now;
					want.scan_mm = seen;
					expected_scans.push_back(want);
					kept_range = '0;
				end
			end

			fail_count      <= mismatches;
			pending         <= expected_scans.size();
			results_checked <= checked;
		end
	end

endmodule

// ===== test/lidar_sector_merge_sequencer_tb.sv =====
`timescale 1ns / 1ps
// Testbench top for the lidar sector merge sequencer: drives lidar scans and register
// setups, stalls the result side and reports the verdict.
// Depends on lsms_pkg, lsms_scan_checker and lidar_sector_merge_sequencer.
module lidar_sector_merge_sequencer_tb;
	import lsms_pkg::*;

	localparam int PHASES        = 8;
	localparam int PHASE_POINTS  = 120;
	localparam int SETTLE_CYCLES = 4;
	localparam int IDLE_LIMIT    = 2000;

	typedef struct packed {
		logic signed [ANGLE_W-1:0] angle;
		logic [RANGE_W-1:0]        mm;
		logic                      has_return;
		logic                      last;
	} point_t;

	typedef struct {
		logic [SPEED_W-1:0]        speed;
		logic [STEER_W-1:0]        steer_l;
		logic [STEER_W-1:0]        steer_s;
		logic [TICK_W-1:0]         wait_n;
		logic signed [ANGLE_W-1:0] amin;
		logic signed [ANGLE_W-1:0] amax;
		logic [RANGE_W-1:0]        rmin_rear;
		logic [RANGE_W-1:0]        rmin_front;
	} setup_t;

	logic                      clk = 1'b0;
	logic                      arst_n = 1'b0;
	logic                      cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]      cfg_index = '0;
	logic [CFG_DATA_W-1:0]     cfg_data = '0;
	logic                      in_valid = 1'b0;
	logic                      in_ready;
	logic signed [ANGLE_W-1:0] point_angle = '0;
	logic [RANGE_W-1:0]        point_range = '0;
	logic                      point_valid = 1'b0;
	logic                      scan_last = 1'b0;
	logic                      out_valid;
	logic                      out_ready = 1'b0;
	logic [STEER_W-1:0]        steer_cmd;
	logic [SPEED_W-1:0]        speed_cmd;
	logic                      merge_done;
	logic [RANGE_W-1:0]        scan_range;

	int   fail_count;
	int   pending;
	int   results_checked;
	logic done_reached;

	setup_t cur;
	int burst_left = 0;
	int ready_left = 0;
	int idle_cycles = 0;
	int points_sent = 0;
	int setups_applied = 0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	lidar_sector_merge_sequencer DUT (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.point_angle (point_angle),
		.point_range (point_range),
		.point_valid (point_valid),
		.scan_last   (scan_last),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.steer_cmd   (steer_cmd),
		.speed_cmd   (speed_cmd),
		.merge_done  (merge_done),
		.scan_range  (scan_range)
	);

	lsms_scan_checker u_checker (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.point_angle     (point_angle),
		.point_range     (point_range),
		.point_valid     (point_valid),
		.scan_last       (scan_last),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.steer_cmd       (steer_cmd),
		.speed_cmd       (speed_cmd),
		.merge_done      (merge_done),
		.scan_range      (scan_range),
		.fail_count      (fail_count),
		.pending         (pending),
		.results_checked (results_checked),
		.done_reached    (done_reached)
	);

	// Result side: hold ready high or low for random stretches, with rare long stalls
	always @(posedge clk) begin
		int pick;
		if (ready_left == 0) begin
			pick = $urandom_range(0, 9);
			if (pick < 6) begin
				out_ready <= 1'b1;
				ready_left = $urandom_range(1, 30);
			end else if (pick < 9) begin
				out_ready <= 1'b0;
				ready_left = $urandom_range(1, 6);
			end else begin
				out_ready <= 1'b0;
				ready_left = $urandom_range(20, 50);
			end
		end else begin
			ready_left--;
		end
	end

	// Watchdog: end the run when no transaction moves for too long
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("Watchdog: no transaction for %0d cycles", IDLE_LIMIT);
			$display("RESULT: ERROR");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	function automatic point_t mk_point(input int a, input int r, input bit pv, input bit last);
		point_t p;
		p.angle      = ANGLE_W'(a);
		p.mm         = RANGE_W'(r);
		p.has_return = pv;
		p.last       = last;
		return p;
	endfunction

	// Offer one point; open a new burst after a random gap when the current one runs out
	task automatic send_point(input point_t p);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap != 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
				: $urandom_range(1, 16);
		end
		burst_left--;
		in_valid    <= 1'b1;
		point_angle <= p.angle;
		point_range <= p.mm;
		point_valid <= p.has_return;
		scan_last   <= p.last;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		points_sent++;
	endtask

	// Stop sending and wait until every predicted result has been taken
	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Write all registers, with random filler above the narrow ones
	task automatic apply_setup(input setup_t s);
		logic [CFG_DATA_W-1:0] word;
		logic [CFG_IDX_W-1:0]  idx;
		int i;
		for (i = 0; i <= int'(REG_FRONT_RANGE_MIN); i++) begin
			idx  = CFG_IDX_W'(i);
			word = CFG_DATA_W'($urandom);
			case (idx)
				REG_MERGE_SPEED:     word = s.speed;
				REG_STEER_LEFT:      word[STEER_W-1:0] = s.steer_l;
				REG_STEER_STRAIGHT:  word[STEER_W-1:0] = s.steer_s;
				REG_WAIT_TICKS:      word[TICK_W-1:0] = s.wait_n;
				REG_REAR_ANGLE_MIN:  word[ANGLE_W-1:0] = s.amin;
				REG_REAR_ANGLE_MAX:  word[ANGLE_W-1:0] = s.amax;
				REG_REAR_RANGE_MIN:  word[RANGE_W-1:0] = s.rmin_rear;
				REG_FRONT_RANGE_MIN: word[RANGE_W-1:0] = s.rmin_front;
				default: ;
			endcase
			cfg_we    <= 1'b1;
			cfg_index <= idx;
			cfg_data  <= word;
			@(posedge clk);
		end
		cfg_we <= 1'b0;
		cur = s;
		setups_applied++;
	endtask

	initial begin
		setup_t s;
		point_t p;
		int ph, n, len, k, lo, hi;
		cur = '{RST_MERGE_SPEED, RST_STEER_LEFT, RST_STEER_STRAIGHT, RST_WAIT_TICKS,
			RST_REAR_ANGLE_MIN, RST_REAR_ANGLE_MAX, RST_REAR_RANGE_MIN, RST_FRONT_RANGE_MIN};
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Idle scan: field extremes, window edges just missed, no-return and zero range
		send_point(mk_point(-2048, 16383, 1, 0));
		send_point(mk_point(2047, 0, 1, 0));
		send_point(mk_point(-1800, 800, 1, 0));
		send_point(mk_point(1800, 801, 1, 0));
		send_point(mk_point(799, 500, 1, 0));
		send_point(mk_point(900, 399, 1, 0));
		send_point(mk_point(1000, 500, 0, 0));
		send_point(mk_point(1000, 0, 1, 1));
		// Object on the upper corner of the rear window starts the waiting phase
		send_point(mk_point(1800, 800, 1, 0));
		send_point(mk_point(0, 16383, 0, 1));
		// Pull-out blocked by an object on the lower corner
		send_point(mk_point(800, 400, 1, 1));
		// Clear scan starts the left pull-out, later objects no longer stop it
		send_point(mk_point(0, 0, 0, 1));
		send_point(mk_point(1500, 600, 1, 1));
		settle();

		for (ph = 0; ph < PHASES; ph++) begin
			if (ph == 0) begin
				// Upper extremes, rear window inverted and front window unreachable
				s = '{16'hFFFF, 8'hFF, 8'hFF, 8'hFF, 12'sd1800, -12'sd1800, 14'h3FFF, 14'h3FFF};
			end else if (ph == 2) begin
				s = '{16'h0, 8'h0, 8'h0, 8'h0, -12'sd1800, 12'sd1800, 14'h0, 14'h0};
			end else begin
				s.speed   = SPEED_W'($urandom);
				s.steer_l = STEER_W'($urandom);
				s.steer_s = STEER_W'($urandom);
				s.wait_n  = TICK_W'($urandom_range(0, 12));
				lo = int'($urandom_range(0, 3600)) - 1800;
				hi = ($urandom_range(0, 4) == 0) ? int'($urandom_range(0, 3600)) - 1800
					: lo + int'($urandom_range(0, 1800 - lo));
				s.amin = ANGLE_W'(lo);
				s.amax = ANGLE_W'(hi);
				s.rmin_rear  = RANGE_W'(($urandom_range(0, 5) == 0) ? $urandom
					: $urandom_range(0, 900));
				s.rmin_front = RANGE_W'(($urandom_range(0, 5) == 0) ? $urandom
					: $urandom_range(0, 350));
			end
			apply_setup(s);

			// Whole scans with random content, biased toward window and band edges
			n = 0;
			while (n < PHASE_POINTS) begin
				len = ($urandom_range(0, 9) == 0) ? $urandom_range(12, 32) : $urandom_range(1, 8);
				for (k = 0; k < len; k++) begin
					case ($urandom_range(0, 9))
						0, 1, 2: begin
							lo = cur.amin;
							hi = cur.amax;
							if (hi < lo) begin
								lo = -1800;
								hi = 1800;
							end
							p.angle = ANGLE_W'(lo + int'($urandom_range(0, hi - lo)));
						end
						3, 4, 5: p.angle = ANGLE_W'(FRONT_ANGLE_MIN + int'($urandom_range(0, 450)));
						6: begin
							case ($urandom_range(0, 7))
								0: p.angle = ANGLE_W'(cur.amin - 1);
								1: p.angle = cur.amin;
								2: p.angle = cur.amax;
								3: p.angle = ANGLE_W'(cur.amax + 1);
								4: p.angle = ANGLE_W'(FRONT_ANGLE_MIN - 1);
								5: p.angle = FRONT_ANGLE_MIN;
								6: p.angle = FRONT_ANGLE_MAX;
								default: p.angle = ANGLE_W'(FRONT_ANGLE_MAX + 1);
							endcase
						end
						7: p.angle = ANGLE_W'($urandom);
						default: p.angle = ANGLE_W'(int'($urandom_range(0, 3600)) - 1800);
					endcase
					case ($urandom_range(0, 9))
						0, 1, 2, 3: p.mm = RANGE_W'($urandom_range(0, 1000));
						4: p.mm = RANGE_W'($urandom_range(DONE_RANGE_LO, DONE_RANGE_HI));
						5: begin
							case ($urandom_range(0, 11))
								0: p.mm = RANGE_W'(DONE_RANGE_LO - 1);
								1: p.mm = DONE_RANGE_LO;
								2: p.mm = RANGE_W'(DONE_RANGE_LO + 1);
								3: p.mm = RANGE_W'(DONE_RANGE_HI - 1);
								4: p.mm = DONE_RANGE_HI;
								5: p.mm = RANGE_W'(DONE_RANGE_HI + 1);
								6: p.mm = RANGE_MAX_MM;
								7: p.mm = RANGE_W'(RANGE_MAX_MM + 1);
								8: p.mm = RANGE_W'(cur.rmin_rear - 1);
								9: p.mm = cur.rmin_rear;
								10: p.mm = RANGE_W'(cur.rmin_front - 1);
								default: p.mm = cur.rmin_front;
							endcase
						end
						6: p.mm = RANGE_W'($urandom);
						default: p.mm = RANGE_W'($urandom_range(300, 850));
					endcase
					p.has_return = ($urandom_range(0, 6) != 0);
					p.last = (k == len - 1);
					send_point(p);
				end
				n += len;
				// Now and then hold off until every pending result is out
				if ($urandom_range(0, 39) == 0)
					settle();
			end
			settle();
		end

		$display("Sent %0d points under %0d register setups, checked %0d scan results;",
			points_sent, setups_applied, results_checked);
		$display("merge completion %s during the run",
			done_reached ? "was reached" : "was not reached");
		if (fail_count == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule
